FILE: rtl/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int SIZE_W      = 7;
    localparam int GEN_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] RESET_SIZE   = SIZE_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef logic [MAX_COLUMNS-1:0] t_row;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL_RD,
        S_CELL_DO,
        S_RESP,
        S_G_START,
        S_G_RD2,
        S_G_LOAD,
        S_G_CELL,
        S_G_WB,
        S_G_END
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        t_row             wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [2:0] above;
        logic [2:0] mid;
        logic [2:0] below;
    } t_nbhd;

endpackage

FILE: rtl/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Game of Life (B3/S23) grid engine: cell write, cell read, run generations.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one word per op. op 0 writes a cell,
// op 1 reads a cell, op 2 runs i_generation_count generations, op 3 does
// nothing. Output channel (o_valid / i_stall): one word for a read (kind 0)
// or for a finished run (kind 1); a write gives none.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
// column count, index 1 the row count, frame included; write only when idle.
// A write passes the cell read and cell update states; a read passes them
// and the response state, then shows o_valid from the output register. A run
// handles one cell per cycle through the shared rule unit, plus one row
// write-back and one row fetch per row on the row store, which takes a read
// and a write together. A run stops early once a generation changes nothing.
// One op is in flight at a time; o_stall is high until it is done.
// The result sits in an output register; while i_stall holds it, a new op is
// still accepted and only waits when its own result is ready.
// Reset: the grid reads all dead at once (per-row valid bits), both sizes
// return to 64.
// ----------------------------------------------------------------------------
module life_grid_generation_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_op,
    input  logic [5:0]                    i_cell_column,
    input  logic [5:0]                    i_cell_row,
    input  logic                          i_alive_in,
    input  logic [lgge_pkg::GEN_W-1:0]    i_generation_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_result_kind,
    output logic                          o_alive_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lgge_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgge_pkg::SIZE_W-1:0]   i_cfg_data
);

    lgge_pkg::t_state               r_state, n_state;
    logic [lgge_pkg::SIZE_W-1:0]    r_cfg_cols, r_cfg_rows;
    logic [1:0]                     r_op, n_op;
    logic [lgge_pkg::COL_W-1:0]     r_col, n_col;
    logic [lgge_pkg::ROW_W-1:0]     r_row, n_row;
    logic                           r_alive, n_alive;
    logic [lgge_pkg::GEN_W-1:0]     r_left, n_left;
    logic                           r_changed, n_changed;
    logic [lgge_pkg::ROW_W-1:0]     r_grow, n_grow;
    logic [lgge_pkg::COL_W-1:0]     r_gcol, n_gcol;
    lgge_pkg::t_row                 r_prev, n_prev;
    lgge_pkg::t_row                 r_cur, n_cur;
    lgge_pkg::t_row                 r_cur_raw, n_cur_raw;
    lgge_pkg::t_row                 r_next, n_next;
    lgge_pkg::t_row                 r_next_raw, n_next_raw;
    lgge_pkg::t_row                 r_new, n_new;
    logic                           r_res_kind, n_res_kind;
    logic                           r_res_alive, n_res_alive;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_kind, n_out_kind;
    logic                           r_out_alive, n_out_alive;

    logic [lgge_pkg::SIZE_W-1:0]    cols_eff, rows_eff, cols_last, rows_last;
    lgge_pkg::t_row                 col_mask;
    lgge_pkg::t_row                 rd_data;
    lgge_pkg::t_mem_req             mem_req;
    lgge_pkg::t_nbhd                nbhd;
    logic                           cell_next;
    logic                           in_accept, out_accept, out_free;
    logic                           cell_interior, next_row_interior;
    logic [lgge_pkg::COL_W-1:0]     gcol_lo, gcol_hi;

    lgge_row_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    lgge_cell_unit u_cell (
        .i_nbhd  (nbhd),
        .o_alive (cell_next)
    );

    always_comb begin
        if (r_cfg_cols < lgge_pkg::MIN_SIZE) begin
            cols_eff = lgge_pkg::MIN_SIZE;
        end else if (r_cfg_cols > lgge_pkg::SIZE_W'(lgge_pkg::MAX_COLUMNS)) begin
            cols_eff = lgge_pkg::SIZE_W'(lgge_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = r_cfg_cols;
        end
        if (r_cfg_rows < lgge_pkg::MIN_SIZE) begin
            rows_eff = lgge_pkg::MIN_SIZE;
        end else if (r_cfg_rows > lgge_pkg::SIZE_W'(lgge_pkg::MAX_ROWS)) begin
            rows_eff = lgge_pkg::SIZE_W'(lgge_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_cfg_rows;
        end
        cols_last = cols_eff - lgge_pkg::SIZE_W'(2);
        rows_last = rows_eff - lgge_pkg::SIZE_W'(2);
    end

    always_comb begin
        for (int b = 0; b < lgge_pkg::MAX_COLUMNS; b++) begin
            col_mask[b] = (b >= 1) && (b <= int'(cols_last));
        end
    end

    assign cell_interior = (r_row != '0) && (lgge_pkg::SIZE_W'(r_row) <= rows_last)
                        && (r_col != '0) && (lgge_pkg::SIZE_W'(r_col) <= cols_last);
    assign next_row_interior = (lgge_pkg::SIZE_W'(r_grow) + lgge_pkg::SIZE_W'(1)) <= rows_last;

    assign gcol_lo = lgge_pkg::COL_W'(r_gcol - 1'b1);
    assign gcol_hi = lgge_pkg::COL_W'(r_gcol + 1'b1);

    always_comb begin
        nbhd.above = {r_prev[gcol_hi], r_prev[r_gcol], r_prev[gcol_lo]};
        nbhd.mid   = {r_cur[gcol_hi],  r_cur[r_gcol],  r_cur[gcol_lo]};
        nbhd.below = {r_next[gcol_hi], r_next[r_gcol], r_next[gcol_lo]};
    end

    assign in_accept  = i_valid && !o_stall;
    assign out_accept = r_out_valid && !i_stall;
    assign out_free   = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_col       = r_col;
        n_row       = r_row;
        n_alive     = r_alive;
        n_left      = r_left;
        n_changed   = r_changed;
        n_grow      = r_grow;
        n_gcol      = r_gcol;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_cur_raw   = r_cur_raw;
        n_next      = r_next;
        n_next_raw  = r_next_raw;
        n_new       = r_new;
        n_res_kind  = r_res_kind;
        n_res_alive = r_res_alive;
        n_out_valid = out_accept ? 1'b0 : r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_alive = r_out_alive;
        mem_req     = '0;

        unique case (r_state)
            lgge_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_op    = i_op;
                    n_col   = i_cell_column;
                    n_row   = i_cell_row;
                    n_alive = i_alive_in;
                    n_left  = i_generation_count;
                    if (i_op == lgge_pkg::OP_WRITE || i_op == lgge_pkg::OP_READ) begin
                        n_state = lgge_pkg::S_CELL_RD;
                    end else if (i_op == lgge_pkg::OP_RUN) begin
                        n_state = lgge_pkg::S_G_START;
                    end
                end
            end
            lgge_pkg::S_CELL_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_row;
                n_state         = lgge_pkg::S_CELL_DO;
            end
            lgge_pkg::S_CELL_DO: begin
                if (r_op == lgge_pkg::OP_WRITE) begin
                    mem_req.wr_en          = cell_interior;
                    mem_req.wr_addr        = r_row;
                    mem_req.wr_data        = rd_data;
                    mem_req.wr_data[r_col] = r_alive;
                    n_state                = lgge_pkg::S_IDLE;
                end else begin
                    n_res_kind  = lgge_pkg::KIND_READ;
                    n_res_alive = cell_interior && rd_data[r_col];
                    n_state     = lgge_pkg::S_RESP;
                end
            end
            lgge_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_alive = r_res_alive;
                    n_state     = lgge_pkg::S_IDLE;
                end
            end
            lgge_pkg::S_G_START: begin
                if (r_left == '0) begin
                    n_res_kind  = lgge_pkg::KIND_RUN;
                    n_res_alive = 1'b0;
                    n_state     = lgge_pkg::S_RESP;
                end else begin
                    n_left          = r_left - 1'b1;
                    n_changed       = 1'b0;
                    n_grow          = lgge_pkg::ROW_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = lgge_pkg::ROW_W'(1);
                    n_state         = lgge_pkg::S_G_RD2;
                end
            end
            lgge_pkg::S_G_RD2: begin
                n_prev          = '0;
                n_cur_raw       = rd_data;
                n_cur           = rd_data & col_mask;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = lgge_pkg::ROW_W'(2);
                n_state         = lgge_pkg::S_G_LOAD;
            end
            lgge_pkg::S_G_LOAD: begin
                n_next_raw = rd_data;
                n_next     = next_row_interior ? (rd_data & col_mask) : '0;
                n_new      = r_cur_raw;
                n_gcol     = lgge_pkg::COL_W'(1);
                n_state    = lgge_pkg::S_G_CELL;
            end
            lgge_pkg::S_G_CELL: begin
                n_new[r_gcol] = cell_next;
                if (cell_next != r_cur[r_gcol]) begin
                    n_changed = 1'b1;
                end
                if (lgge_pkg::SIZE_W'(r_gcol) == cols_last) begin
                    n_state = lgge_pkg::S_G_WB;
                end else begin
                    n_gcol = gcol_hi;
                end
            end
            lgge_pkg::S_G_WB: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_grow;
                mem_req.wr_data = r_new;
                n_prev          = r_cur;
                n_cur           = r_next;
                n_cur_raw       = r_next_raw;
                if (lgge_pkg::SIZE_W'(r_grow) == rows_last) begin
                    n_state = lgge_pkg::S_G_END;
                end else begin
                    n_grow          = lgge_pkg::ROW_W'(r_grow + 1'b1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = lgge_pkg::ROW_W'(r_grow + 2'd2);
                    n_state         = lgge_pkg::S_G_LOAD;
                end
            end
            lgge_pkg::S_G_END: begin
                if (!r_changed) begin
                    n_left = '0;
                end
                n_state = lgge_pkg::S_G_START;
            end
            default: begin
                n_state = lgge_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lgge_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_cfg_cols  <= lgge_pkg::RESET_SIZE;
            r_cfg_rows  <= lgge_pkg::RESET_SIZE;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == lgge_pkg::CFG_COLUMNS) begin
                    r_cfg_cols <= i_cfg_data;
                end else if (i_cfg_index == lgge_pkg::CFG_ROWS) begin
                    r_cfg_rows <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_col       <= n_col;
        r_row       <= n_row;
        r_alive     <= n_alive;
        r_changed   <= n_changed;
        r_grow      <= n_grow;
        r_gcol      <= n_gcol;
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_cur_raw   <= n_cur_raw;
        r_next      <= n_next;
        r_next_raw  <= n_next_raw;
        r_new       <= n_new;
        r_res_kind  <= n_res_kind;
        r_res_alive <= n_res_alive;
        r_out_kind  <= n_out_kind;
        r_out_alive <= n_out_alive;
    end

    assign o_stall       = (r_state != lgge_pkg::S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_alive_out   = r_out_alive;
    assign o_cfg_ready   = 1'b1;

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state == lgge_pkg::S_RESP))
        else $error("result word loaded outside the response state");

    a_wb_interior_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgge_pkg::S_G_WB) |->
            (r_grow != '0 && lgge_pkg::SIZE_W'(r_grow) <= rows_last))
        else $error("generation write-back hit a frame row");

    a_cell_interior_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgge_pkg::S_G_CELL) |->
            (r_gcol != '0 && lgge_pkg::SIZE_W'(r_gcol) <= cols_last))
        else $error("rule unit applied to a frame column");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op == lgge_pkg::OP_RUN) |=> o_stall)
        else $error("run accepted but engine not busy");

endmodule

FILE: rtl/lgge_row_mem.sv
// ----------------------------------------------------------------------------
// lgge_row_mem
// Grid store, one row per word, registered read, per-row valid bits so the
// grid reads dead right after reset.
// ----------------------------------------------------------------------------
module lgge_row_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lgge_pkg::t_mem_req i_req,
    output lgge_pkg::t_row     o_rd_data
);

    lgge_pkg::t_row                  r_mem [lgge_pkg::MAX_ROWS];
    lgge_pkg::t_row                  r_rd_data;
    logic [lgge_pkg::MAX_ROWS-1:0]   r_row_vld;
    logic                            r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: rtl/lgge_cell_unit.sv
// ----------------------------------------------------------------------------
// lgge_cell_unit
// Shared B3/S23 rule unit: counts the eight neighbors of one cell and gives
// its next state.
// ----------------------------------------------------------------------------
module lgge_cell_unit (
    input  lgge_pkg::t_nbhd i_nbhd,
    output logic            o_alive
);

    logic [3:0] count;
    logic       center;

    always_comb begin
        count = 4'(i_nbhd.above[0]) + 4'(i_nbhd.above[1]) + 4'(i_nbhd.above[2])
              + 4'(i_nbhd.mid[0])                         + 4'(i_nbhd.mid[2])
              + 4'(i_nbhd.below[0]) + 4'(i_nbhd.below[1]) + 4'(i_nbhd.below[2]);
        center = i_nbhd.mid[1];
        if (count == 4'd3) begin
            o_alive = 1'b1;
        end else if (count == 4'd2) begin
            o_alive = center;
        end else begin
            o_alive = 1'b0;
        end
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the life grid generation engine.
// A scoreboard object keeps its own copy of the cell grid and the two size
// registers. It steps B3/S23 generations for every accepted run word and
// queues the reply that each read or run must produce. Replies are checked
// in order. A short directed part at the reset size comes first. Random
// phases follow over many grid sizes, out-of-range sizes among them. Most
// random traffic is fill / run / read-back bursts with noise mixed in, and
// both sides of the word channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         SETTLE      = 12;
    localparam int         PHASE_WORDS = 170;
    localparam int         PHASES      = 10;

    typedef struct packed {
        logic [1:0]                 op;
        logic [5:0]                 col;
        logic [5:0]                 row;
        logic                       alive;
        logic [lgge_pkg::GEN_W-1:0] count;
    } t_life_word;

    typedef struct packed {
        logic kind;
        logic alive;
    } t_reply;

    class life_scoreboard;
        bit [lgge_pkg::MAX_COLUMNS-1:0] cells [lgge_pkg::MAX_ROWS];
        logic [lgge_pkg::SIZE_W-1:0]    columns_reg;
        logic [lgge_pkg::SIZE_W-1:0]    rows_reg;
        t_reply                         awaited_replies [$];
        int                             errors;

        function new();
            foreach (cells[r]) cells[r] = '0;
            columns_reg = lgge_pkg::RESET_SIZE;
            rows_reg    = lgge_pkg::RESET_SIZE;
            errors      = 0;
        endfunction

        function int used_size(logic [lgge_pkg::SIZE_W-1:0] v, int limit);
            if (v < lgge_pkg::MIN_SIZE) return int'(lgge_pkg::MIN_SIZE);
            if (v > limit) return limit;
            return int'(v);
        endfunction

        function int eff_columns();
            return used_size(columns_reg, lgge_pkg::MAX_COLUMNS);
        endfunction

        function int eff_rows();
            return used_size(rows_reg, lgge_pkg::MAX_ROWS);
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        function void note_config(logic [lgge_pkg::CFG_IDX_W-1:0] idx,
                                  logic [lgge_pkg::SIZE_W-1:0] data);
            if (idx == lgge_pkg::CFG_COLUMNS) columns_reg = data;
            else rows_reg = data;
        endfunction

        // frame and out-of-grid cells count as dead
        function int live_at(int r, int c, int rows, int cols);
            if (r < 1 || r >= rows - 1 || c < 1 || c >= cols - 1) return 0;
            return int'(cells[r][c]);
        endfunction

        function bit advance_generation(int rows, int cols);
            bit [lgge_pkg::MAX_COLUMNS-1:0] nxt [lgge_pkg::MAX_ROWS];
            bit changed;
            bit cur;
            bit born;
            int n;
            nxt = cells;
            changed = 1'b0;
            for (int r = 1; r + 1 < rows; r++) begin
                for (int c = 1; c + 1 < cols; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc, rows, cols);
                    cur  = cells[r][c];
                    born = (n == 3) || (n == 2 && cur);
                    nxt[r][c] = born;
                    if (born != cur) changed = 1'b1;
                end
            end
            cells = nxt;
            return changed;
        endfunction

        function void note_input(t_life_word w);
            int     ec;
            int     er;
            int     left;
            bit     inner;
            t_reply rep;
            ec = eff_columns();
            er = eff_rows();
            inner = (w.row >= 1) && (w.row + 1 < er) && (w.col >= 1) && (w.col + 1 < ec);
            case (w.op)
                lgge_pkg::OP_WRITE: begin
                    if (inner) cells[w.row][w.col] = w.alive;
                end
                lgge_pkg::OP_READ: begin
                    rep.kind  = lgge_pkg::KIND_READ;
                    rep.alive = inner ? cells[w.row][w.col] : 1'b0;
                    awaited_replies.push_back(rep);
                end
                lgge_pkg::OP_RUN: begin
                    left = w.count;
                    // a generation that changes nothing ends the run
                    while (left != 0) begin
                        left--;
                        if (!advance_generation(er, ec)) left = 0;
                    end
                    rep.kind  = lgge_pkg::KIND_RUN;
                    rep.alive = 1'b0;
                    awaited_replies.push_back(rep);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic kind, logic alive);
            t_reply want;
            if (awaited_replies.size() == 0) begin
                $display("%0t: expected no reply, actual kind %0b alive %0b",
                         $time, kind, alive);
                errors++;
                return;
            end
            want = awaited_replies.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: result_kind expected %0b actual %0b", $time, want.kind, kind);
                errors++;
            end
            if (alive !== want.alive) begin
                $display("%0t: alive_out expected %0b actual %0b", $time, want.alive, alive);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_valid            = 1'b0;
    logic                           o_stall;
    logic [1:0]                     i_op               = lgge_pkg::OP_WRITE;
    logic [5:0]                     i_cell_column      = '0;
    logic [5:0]                     i_cell_row         = '0;
    logic                           i_alive_in         = 1'b0;
    logic [lgge_pkg::GEN_W-1:0]     i_generation_count = '0;
    logic                           o_valid;
    logic                           i_stall            = 1'b0;
    logic                           o_result_kind;
    logic                           o_alive_out;
    logic                           i_cfg_valid        = 1'b0;
    logic                           o_cfg_ready;
    logic [lgge_pkg::CFG_IDX_W-1:0] i_cfg_index        = lgge_pkg::CFG_COLUMNS;
    logic [lgge_pkg::SIZE_W-1:0]    i_cfg_data         = lgge_pkg::RESET_SIZE;

    life_scoreboard sb = new();
    int gap_pct    = 20;
    int stall_pct  = 20;
    int stall_left = 0;

    life_grid_generation_engine u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_op               (i_op),
        .i_cell_column      (i_cell_column),
        .i_cell_row         (i_cell_row),
        .i_alive_in         (i_alive_in),
        .i_generation_count (i_generation_count),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_kind      (o_result_kind),
        .o_alive_out        (o_alive_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // result monitor and receiver stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_result_kind, o_alive_out);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(14, 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic t_life_word life_word(logic [1:0] op, int col, int row, bit alive,
                                             int count);
        t_life_word w;
        w.op    = op;
        w.col   = 6'(col);
        w.row   = 6'(row);
        w.alive = alive;
        w.count = lgge_pkg::GEN_W'(count);
        return w;
    endfunction

    // thin grids settle fast, so half of their runs take the whole count range
    function automatic logic [lgge_pkg::GEN_W-1:0] run_count(int ec, int er);
        if (ec <= 3 || er <= 3 || (ec <= 4 && er <= 4)) begin
            if ($urandom_range(1, 0)) return lgge_pkg::GEN_W'($urandom_range(65535, 0));
            return lgge_pkg::GEN_W'($urandom_range(6, 0));
        end
        if (ec * er <= 300) return lgge_pkg::GEN_W'($urandom_range(12, 0));
        return lgge_pkg::GEN_W'($urandom_range(2, 0));
    endfunction

    function automatic int pick_size();
        int p;
        p = $urandom_range(99, 0);
        if (p < 70) return $urandom_range(16, 3);
        if (p < 85) return $urandom_range(2, 0);
        return $urandom_range(127, 65);
    endfunction

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_word(t_life_word w);
        if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) idle_gap($urandom_range(15, 1));
        i_valid            <= 1'b1;
        i_op               <= w.op;
        i_cell_column      <= w.col;
        i_cell_row         <= w.row;
        i_alive_in         <= w.alive;
        i_generation_count <= w.count;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_input(w);
    endtask

    task automatic drain_replies();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [lgge_pkg::CFG_IDX_W-1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= lgge_pkg::SIZE_W'(data);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.note_config(idx, lgge_pkg::SIZE_W'(data));
    endtask

    task automatic write_sizes(int cols, int rows);
        cfg_write(lgge_pkg::CFG_COLUMNS, cols);
        cfg_write(lgge_pkg::CFG_ROWS, rows);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_words();
        send_word(life_word(lgge_pkg::OP_RUN, 0, 0, 0, 65535));   // empty grid stops at once
        send_word(life_word(lgge_pkg::OP_RUN, 63, 63, 1, 0));
        send_word(life_word(lgge_pkg::OP_WRITE, 5, 0, 1, 0));     // frame, ignored
        send_word(life_word(lgge_pkg::OP_WRITE, 63, 63, 1, 0));
        send_word(life_word(lgge_pkg::OP_WRITE, 62, 62, 1, 0));
        send_word(life_word(lgge_pkg::OP_WRITE, 1, 1, 1, 0));
        send_word(life_word(lgge_pkg::OP_WRITE, 10, 10, 1, 0));   // blinker
        send_word(life_word(lgge_pkg::OP_WRITE, 11, 10, 1, 0));
        send_word(life_word(lgge_pkg::OP_WRITE, 12, 10, 1, 0));
        send_word(life_word(lgge_pkg::OP_READ, 5, 0, 0, 0));
        send_word(life_word(lgge_pkg::OP_READ, 63, 63, 0, 0));
        send_word(life_word(lgge_pkg::OP_READ, 62, 62, 1, 0));
        send_word(life_word(lgge_pkg::OP_READ, 1, 1, 0, 0));
        send_word(life_word(OP_NONE, 11, 10, 1, 7));
        send_word(life_word(lgge_pkg::OP_RUN, 0, 0, 0, 1));
        send_word(life_word(lgge_pkg::OP_READ, 11, 9, 0, 0));
        send_word(life_word(lgge_pkg::OP_READ, 11, 11, 0, 0));
        send_word(life_word(lgge_pkg::OP_READ, 10, 10, 0, 0));
        send_word(life_word(lgge_pkg::OP_READ, 62, 62, 0, 0));
        send_word(life_word(lgge_pkg::OP_RUN, 0, 0, 0, 2));
        send_word(life_word(lgge_pkg::OP_READ, 10, 10, 0, 0));
        send_word(life_word(lgge_pkg::OP_WRITE, 11, 10, 0, 0));
        send_word(life_word(lgge_pkg::OP_READ, 11, 10, 0, 0));
    endtask

    task automatic random_phase(int budget);
        int         done;
        int         ec;
        int         er;
        int         bc;
        int         br;
        int         p;
        int         col;
        int         row;
        t_life_word w;
        done = 0;
        ec = sb.eff_columns();
        er = sb.eff_rows();
        while (done < budget) begin
            if ($urandom_range(99, 0) < 15) begin
                w = life_word(2'($urandom_range(3, 0)), $urandom_range(63, 0),
                              $urandom_range(63, 0), 1'($urandom_range(1, 0)),
                              $urandom_range(65535, 0));
                if (w.op == lgge_pkg::OP_RUN) w.count = run_count(ec, er);
                send_word(w);
                if (w.op != OP_NONE) done++;
            end else begin
                // fill a small window, run, then read back
                bc = $urandom_range(ec - 2, 1);
                br = $urandom_range(er - 2, 1);
                repeat ($urandom_range(12, 3)) begin
                    col = bc + $urandom_range(4, 0);
                    row = br + $urandom_range(4, 0);
                    if (col > ec - 2) col = ec - 2;
                    if (row > er - 2) row = er - 2;
                    send_word(life_word(lgge_pkg::OP_WRITE, col, row,
                                        $urandom_range(99, 0) < 55,
                                        $urandom_range(65535, 0)));
                    done++;
                end
                w = life_word(lgge_pkg::OP_RUN, $urandom_range(63, 0), $urandom_range(63, 0),
                              1'($urandom_range(1, 0)), 0);
                w.count = run_count(ec, er);
                send_word(w);
                done++;
                repeat ($urandom_range(8, 2)) begin
                    p = $urandom_range(99, 0);
                    if (p < 70) begin
                        col = bc + $urandom_range(4, 0);
                        row = br + $urandom_range(4, 0);
                        if (col > ec - 2) col = ec - 2;
                        if (row > er - 2) row = er - 2;
                    end else if (p < 90) begin
                        col = $urandom_range(ec - 1, 0);
                        row = $urandom_range(er - 1, 0);
                    end else begin
                        col = $urandom_range(63, 0);
                        row = $urandom_range(63, 0);
                    end
                    send_word(life_word(lgge_pkg::OP_READ, col, row,
                                        1'($urandom_range(1, 0)),
                                        $urandom_range(65535, 0)));
                    done++;
                end
            end
            if ($urandom_range(99, 0) < 4) drain_replies();
        end
    endtask

    initial begin
        int fixed_cols [6] = '{3, 0, 127, 4, 64, 2};
        int fixed_rows [6] = '{3, 127, 2, 4, 64, 17};
        int cols;
        int rows;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_words();
        drain_replies();
        for (int p = 0; p < PHASES; p++) begin
            if (p < 6) begin
                cols = fixed_cols[p];
                rows = fixed_rows[p];
            end else begin
                cols = pick_size();
                rows = pick_size();
            end
            write_sizes(cols, rows);
            if (p == PHASES - 1 || p % 3 == 0) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(1, 0) ? 10 : 30;
                stall_pct = $urandom_range(1, 0) ? 10 : 30;
            end
            random_phase(PHASE_WORDS);
            drain_replies();
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
